@@ design/msa_pkg.sv @@
// ----------------------------------------------------------------------------
// msa_pkg
// Shared sizes, widths and control types for the multichannel sample averager.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int CHANNELS      = 5;
  localparam int HISTORY_DEPTH = 10;

  localparam int SAMPLE_W = 10;
  localparam int CHAN_W   = 3;

  // channel index into per-channel state
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // ring position
  localparam int POS_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam int STORE_DEPTH = CHANNELS * HISTORY_DEPTH;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // sum of a full ring
  localparam int SUM_W = SAMPLE_W + $clog2(HISTORY_DEPTH + 1);

  // reciprocal for the divide by the ring length: exact for every SUM_W-bit sum
  localparam int LOG_D    = $clog2(HISTORY_DEPTH);
  localparam int RECIP_SH = SUM_W + LOG_D;
  localparam int RECIP_W  = SUM_W + 1;
  localparam longint RECIP_M = ((64'd1 << RECIP_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_t;

  // store port request from the controller
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ design/msa_ifs.sv @@
// ----------------------------------------------------------------------------
// msa interfaces
// Valid/ready channels for request and average beats.
// ----------------------------------------------------------------------------
interface msa_req_if
  import msa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                action;
  logic [CHAN_W-1:0]   channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output action, output channel, output sample, input ready);
  modport sink   (input valid, input action, input channel, input sample, output ready);
endinterface

interface msa_rsp_if
  import msa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

@@ design/msa_store.sv @@
// ----------------------------------------------------------------------------
// msa_store
// Sample ring memory, one write and one registered read port. Per-entry valid
// flags make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module msa_store
  import msa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  mem_req_t            req,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0]    mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] written;
  logic [SAMPLE_W-1:0]    rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.waddr] <= 1'b1;
      end
      rd_vld <= written[req.raddr];
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

@@ design/msa_div.sv @@
// ----------------------------------------------------------------------------
// msa_div
// Divide of a ring sum by the ring length: reciprocal multiply, registered,
// then a fixed shift.
// ----------------------------------------------------------------------------
module msa_div
  import msa_pkg::*;
(
  input  logic                clk,
  input  logic [SUM_W-1:0]    sum,
  output logic [SAMPLE_W-1:0] quotient
);

  localparam logic [RECIP_W-1:0] RECIP = RECIP_M[RECIP_W-1:0];

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(sum) * PROD_W'(RECIP);
  end

  assign quotient = prod[RECIP_SH +: SAMPLE_W];

endmodule

@@ design/msa_ctrl.sv @@
// ----------------------------------------------------------------------------
// msa_ctrl
// Request sequencer: ring write positions, store writes, the read walk over a
// channel's ring with accumulation, and the output register.
// ----------------------------------------------------------------------------
module msa_ctrl
  import msa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  msa_req_if.sink             req,
  msa_rsp_if.source           rsp,
  output mem_req_t            mem_req,
  input  logic [SAMPLE_W-1:0] rdata,
  output logic [SUM_W-1:0]    sum,
  input  logic [SAMPLE_W-1:0] quotient
);

  state_t state, state_next;

  logic [POS_W-1:0]    pos [CHANNELS];
  logic [POS_W-1:0]    idx;
  logic [ADDR_W-1:0]   base;
  logic                pend;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_data;

  logic                accept;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [ADDR_W-1:0]   ch_base;
  logic [POS_W-1:0]    cur_pos;
  logic                rd_en;
  logic                load_out;
  logic                last_idx;

  assign ch_ok   = ({1'b0, req.channel} < (CHAN_W + 1)'(CHANNELS));
  assign ch_idx  = req.channel[CH_IDX_W-1:0];
  assign ch_base = ADDR_W'(ch_idx) * ADDR_W'(HISTORY_DEPTH);
  assign cur_pos = pos[ch_idx];
  assign accept  = req.valid && req.ready;
  assign last_idx = (idx == POS_W'(HISTORY_DEPTH - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.action == ACT_READ) begin
          state_next = ch_ok ? ST_READ : ST_DIV;
        end
      end
      ST_READ: begin
        if (last_idx) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DIV;
      ST_DIV:   state_next = ST_OUT;
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_OUT:   load_out = !out_valid || rsp.ready;
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_req.wr_en = accept && req.action == ACT_STORE && ch_ok;
    mem_req.waddr = ch_base + ADDR_W'(cur_pos);
    mem_req.wdata = req.sample;
    mem_req.raddr = base + ADDR_W'(idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        pos[c] <= '0;
      end
    end else begin
      state <= state_next;
      pend  <= rd_en;
      if (mem_req.wr_en) begin
        pos[ch_idx] <= (cur_pos == POS_W'(HISTORY_DEPTH - 1)) ? '0 : cur_pos + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base <= ch_base;
      idx  <= '0;
      sum  <= '0;
    end else begin
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
      // read data lands in the cycle after its address
      if (pend) begin
        sum <= sum + SUM_W'(rdata);
      end
    end
    if (load_out) begin
      out_data <= quotient;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.average = out_data;

endmodule

@@ design/multichannel_sample_averager_top.sv @@
// ----------------------------------------------------------------------------
// multichannel_sample_averager_top
// Per-channel moving average over the last ten converter samples.
//
//   channel  dir  beat contents              notes
//   req      in   action, channel, sample    store or read request
//   rsp      out  average                    one beat per read request
//
// A store leaves the sequencer idle, so stores can follow back to back. A read
// walks the ring through the single memory read port, then passes the divide
// register and the output load; a read of an out-of-range channel skips the walk.
// Reset is synchronous; the ring contents read as zero until written.
// A stalled rsp holds the result register; a new request is still taken while
// a finished average waits.
// ----------------------------------------------------------------------------
module multichannel_sample_averager_top
  import msa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  msa_req_if.sink   req,
  msa_rsp_if.source rsp
);

  mem_req_t            mem_req;
  logic [SAMPLE_W-1:0] rdata;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] quotient;

  msa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .mem_req  (mem_req),
    .rdata    (rdata),
    .sum      (sum),
    .quotient (quotient)
  );

  msa_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (rdata)
  );

  msa_div u_div (
    .clk      (clk),
    .sum      (sum),
    .quotient (quotient)
  );

endmodule
